### hdl/mcpat_pkg.sv
// Shared types and constants of the multi-channel periodic alarm timer.
`timescale 1ns / 1ps
`default_nettype none

package mcpat_pkg;

    localparam int CHANNELS = 4;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int TIME_W = 16;
    localparam int SEQ_W  = 32;
    localparam int CH_W   = 2;
    localparam int CFG_W  = 3;

    localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(CHANNELS - 1);
    localparam logic [CFG_W-1:0] IDX_IDLE = 3'd4;

    localparam logic KIND_ALARM   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUMM
    } state_t;

    typedef struct packed {
        logic            start;
        logic            step;
        logic            load_alarm;
        logic            load_summary;
        logic [CH_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic fire;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### hdl/mcpat_ctrl.sv
// Sequencer of the timer: walks the channels, then issues the summary.
`timescale 1ns / 1ps
`default_nettype none

module mcpat_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  mcpat_pkg::status_t  status,
    output mcpat_pkg::cmd_t     cmd
);

    mcpat_pkg::state_t                 state_reg;
    mcpat_pkg::state_t                 state_next;
    logic [mcpat_pkg::CH_W-1:0]        ch_reg;
    logic [mcpat_pkg::CH_W-1:0]        ch_next;
    logic                              advance;

    // A channel step stalls only when it fires and the output is still full.
    assign advance = !status.fire || status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcpat_pkg::ST_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            mcpat_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mcpat_pkg::ST_SCAN;
                    ch_next    = '0;
                end
            end
            mcpat_pkg::ST_SCAN:
            begin
                if (advance)
                begin
                    if (ch_reg == mcpat_pkg::LAST_CH)
                        state_next = mcpat_pkg::ST_SUMM;
                    else
                        ch_next = ch_reg + 1'b1;
                end
            end
            mcpat_pkg::ST_SUMM:
            begin
                if (status.out_free)
                    state_next = mcpat_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mcpat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        cmd              = '0;
        cmd.ch           = ch_reg;
        case (state_reg)
            mcpat_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            mcpat_pkg::ST_SCAN:
            begin
                cmd.step       = advance;
                cmd.load_alarm = advance && status.fire;
            end
            mcpat_pkg::ST_SUMM:
            begin
                cmd.load_summary = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/mcpat_dp.sv
// Datapath of the timer: channel state, running minimum, output register.
`timescale 1ns / 1ps
`default_nettype none

module mcpat_dp (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire  [mcpat_pkg::TIME_W-1:0]         elapsed,
    input  wire                                  cfg_we,
    input  wire  [mcpat_pkg::CFG_W-1:0]          cfg_index,
    input  wire  [mcpat_pkg::TIME_W-1:0]         cfg_wdata,
    input  mcpat_pkg::cmd_t                      cmd,
    output mcpat_pkg::status_t                   status,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic                                 kind,
    output logic [mcpat_pkg::CH_W-1:0]           channel,
    output logic [mcpat_pkg::SEQ_W-1:0]          sequence_res,
    output logic [mcpat_pkg::TIME_W-1:0]         sleep_ticks,
    output logic                                 last
);

    logic [mcpat_pkg::TIME_W-1:0] period_reg    [mcpat_pkg::CHANNELS];
    logic [mcpat_pkg::TIME_W-1:0] remaining_reg [mcpat_pkg::CHANNELS];
    logic [mcpat_pkg::SEQ_W-1:0]  seq_reg       [mcpat_pkg::CHANNELS];
    logic [mcpat_pkg::TIME_W-1:0] idle_reg;
    logic [mcpat_pkg::TIME_W-1:0] elapsed_reg;
    logic                         any_reg;
    logic [mcpat_pkg::TIME_W-1:0] min_reg;
    logic                         out_valid_reg;
    logic                         kind_reg;
    logic [mcpat_pkg::CH_W-1:0]   channel_reg;
    logic [mcpat_pkg::SEQ_W-1:0]  seq_out_reg;
    logic [mcpat_pkg::TIME_W-1:0] sleep_reg;
    logic                         last_reg;

    logic [mcpat_pkg::IDX_W-1:0]  idx;
    logic [mcpat_pkg::TIME_W-1:0] cur_period;
    logic [mcpat_pkg::TIME_W-1:0] cur_rem;
    logic [mcpat_pkg::SEQ_W-1:0]  cur_seq;
    logic                         enabled;
    logic                         hit;
    logic [mcpat_pkg::TIME_W-1:0] rem_next;
    logic                         take_min;
    logic                         out_free;

    assign idx        = cmd.ch[mcpat_pkg::IDX_W-1:0];
    assign cur_period = period_reg[idx];
    assign cur_rem    = remaining_reg[idx];
    assign cur_seq    = seq_reg[idx];
    assign enabled    = (cur_period != '0);
    assign hit        = (elapsed_reg >= cur_rem);
    // no catch-up: a late channel reloads with its full period
    assign rem_next   = hit ? cur_period : (cur_rem - elapsed_reg);
    assign take_min   = enabled && (!any_reg || (rem_next < min_reg));
    assign out_free   = !out_valid_reg || out_ready;

    assign status.fire     = enabled && hit;
    assign status.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcpat_pkg::CHANNELS; i++)
            begin
                period_reg[i]    <= '0;
                remaining_reg[i] <= '0;
                seq_reg[i]       <= mcpat_pkg::SEQ_W'(1);
            end
            idle_reg      <= mcpat_pkg::TIME_W'(1);
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (32'(cfg_index) < mcpat_pkg::CHANNELS)
                begin
                    period_reg[cfg_index[mcpat_pkg::IDX_W-1:0]]    <= cfg_wdata;
                    remaining_reg[cfg_index[mcpat_pkg::IDX_W-1:0]] <= cfg_wdata;
                    seq_reg[cfg_index[mcpat_pkg::IDX_W-1:0]]       <= mcpat_pkg::SEQ_W'(1);
                end
                else if (cfg_index == mcpat_pkg::IDX_IDLE)
                begin
                    idle_reg <= cfg_wdata;
                end
            end

            if (cmd.start)
                any_reg <= 1'b0;
            else if (cmd.step && enabled)
                any_reg <= 1'b1;

            if (cmd.step && enabled)
            begin
                remaining_reg[idx] <= rem_next;
                if (hit)
                    seq_reg[idx] <= cur_seq + 1'b1;
            end

            if (cmd.load_alarm || cmd.load_summary)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            elapsed_reg <= elapsed;
        if (cmd.step && take_min)
            min_reg <= rem_next;
        if (cmd.load_alarm)
        begin
            kind_reg    <= mcpat_pkg::KIND_ALARM;
            channel_reg <= cmd.ch;
            seq_out_reg <= cur_seq;
            sleep_reg   <= '0;
            last_reg    <= 1'b0;
        end
        else if (cmd.load_summary)
        begin
            kind_reg    <= mcpat_pkg::KIND_SUMMARY;
            channel_reg <= '0;
            seq_out_reg <= '0;
            sleep_reg   <= any_reg ? min_reg : idle_reg;
            last_reg    <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign channel      = channel_reg;
    assign sequence_res = seq_out_reg;
    assign sleep_ticks  = sleep_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### hdl/multi_channel_periodic_alarm_timer.sv
// Top level of the multi-channel periodic alarm timer.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    elapsed[15:0]
// output    out_valid / out_ready  kind, channel[1:0], sequence_res[31:0],
//                                  sleep_ticks[15:0], last
// config    cfg_we                 cfg_index[2:0], cfg_wdata[15:0]
//
// An item runs these steps in order when the output drains freely: capture
// elapsed, one step per channel through the shared compare/subtract unit,
// then load the summary.
// A firing channel waits while the single output register is still full.
// Reset (rst_n, async, active low): periods 0, countdowns 0, sequences 1,
// idle_sleep 1, output empty. in_ready is high only between items.

module multi_channel_periodic_alarm_timer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [15:0] elapsed,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        kind,
    output logic [1:0]  channel,
    output logic [31:0] sequence_res,
    output logic [15:0] sleep_ticks,
    output logic        last,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_wdata
);

    // command and status between sequencer and datapath
    mcpat_pkg::cmd_t    cmd;
    mcpat_pkg::status_t status;

    mcpat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mcpat_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .elapsed      (elapsed),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .channel      (channel),
        .sequence_res (sequence_res),
        .sleep_ticks  (sleep_ticks),
        .last         (last)
    );

endmodule

`default_nettype wire

### tb/multi_channel_periodic_alarm_timer_tb.sv
// Self-checking testbench for the multi-channel periodic alarm timer.
`timescale 1ns / 1ps

module multi_channel_periodic_alarm_timer_tb;

    // Cycles with no transfer of any kind before the run is declared hung.
    // The slowest legal item is one pass through the block plus five results, each
    // behind a short random receiver stall, so this is far beyond it.
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling time after the last result before a register write or the end.
    localparam int DRAIN_CYCLES   = 12;
    // Upper bound on one random sender gap, in cycles.
    localparam int GAP_CAP        = 16;
    // Only the first few mismatches are printed.
    localparam int REPORT_LIMIT   = 10;

    // Register map: periods first, then idle_sleep (from the package).
    localparam logic [mcpat_pkg::CFG_W-1:0] REG_PERIOD_CH0  = 3'd0;
    localparam logic [mcpat_pkg::CFG_W-1:0] REG_PERIOD_CH1  = 3'd1;
    localparam logic [mcpat_pkg::CFG_W-1:0] REG_PERIOD_CH2  = 3'd2;
    localparam logic [mcpat_pkg::CFG_W-1:0] REG_PERIOD_CH3  = 3'd3;
    // Indexes past the end of the map; writes there must do nothing.
    localparam logic [mcpat_pkg::CFG_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [mcpat_pkg::CFG_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic                         kind;
        logic [mcpat_pkg::CH_W-1:0]   chan;
        logic [mcpat_pkg::SEQ_W-1:0]  seq_no;
        logic [mcpat_pkg::TIME_W-1:0] sleep;
        logic                         is_last;
    } timer_event_t;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_ready;
    logic [mcpat_pkg::TIME_W-1:0] elapsed      = '0;
    logic                         out_valid;
    logic                         out_ready    = 1'b0;
    logic                         kind;
    logic [mcpat_pkg::CH_W-1:0]   channel;
    logic [mcpat_pkg::SEQ_W-1:0]  sequence_res;
    logic [mcpat_pkg::TIME_W-1:0] sleep_ticks;
    logic                         last;
    logic                         cfg_we       = 1'b0;
    logic [mcpat_pkg::CFG_W-1:0]  cfg_index    = '0;
    logic [mcpat_pkg::TIME_W-1:0] cfg_wdata    = '0;

    // Shadow copy of the timer: periods, countdowns, sequence counters.
    logic [mcpat_pkg::TIME_W-1:0] period_q [mcpat_pkg::CHANNELS];
    logic [mcpat_pkg::TIME_W-1:0] count_q  [mcpat_pkg::CHANNELS];
    logic [mcpat_pkg::SEQ_W-1:0]  seq_q    [mcpat_pkg::CHANNELS];
    logic [mcpat_pkg::TIME_W-1:0] idle_q;

    // Alarms and summaries the timer still owes, oldest first.
    timer_event_t timer_events [$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    multi_channel_periodic_alarm_timer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .elapsed      (elapsed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .channel      (channel),
        .sequence_res (sequence_res),
        .sleep_ticks  (sleep_ticks),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow timer
    // ------------------------------------------------------------------
    task automatic clear_timer_state();
        for (int c = 0; c < mcpat_pkg::CHANNELS; c++)
        begin
            period_q[c] = '0;
            count_q[c]  = '0;
            seq_q[c]    = mcpat_pkg::SEQ_W'(1);
        end
        idle_q = mcpat_pkg::TIME_W'(1);
    endtask

    // A period write reloads the countdown and restarts the sequence at 1.
    task automatic apply_reg_write(input logic [mcpat_pkg::CFG_W-1:0] idx,
                                   input logic [mcpat_pkg::TIME_W-1:0] val);
        if (idx < mcpat_pkg::CHANNELS)
        begin
            period_q[idx] = val;
            count_q[idx]  = val;
            seq_q[idx]    = mcpat_pkg::SEQ_W'(1);
        end
        else if (idx == mcpat_pkg::IDX_IDLE)
        begin
            idle_q = val;
        end
    endtask

    // One tick: walk the enabled channels in order, queue an alarm for each
    // countdown that hits zero or would underflow (reload, no catch-up),
    // then the summary with the smallest countdown left, or idle_sleep if none is on.
    task automatic advance_channels(input logic [mcpat_pkg::TIME_W-1:0] dt);
        timer_event_t                 ev;
        logic                         any_on;
        logic [mcpat_pkg::TIME_W-1:0] least;
        any_on = 1'b0;
        least  = '0;
        for (int c = 0; c < mcpat_pkg::CHANNELS; c++)
        begin
            if (period_q[c] != 0)
            begin
                if (dt >= count_q[c])
                begin
                    ev.kind    = mcpat_pkg::KIND_ALARM;
                    ev.chan    = mcpat_pkg::CH_W'(c);
                    ev.seq_no  = seq_q[c];
                    ev.sleep   = '0;
                    ev.is_last = 1'b0;
                    timer_events.insert(timer_events.size(), ev);
                    seq_q[c]   = seq_q[c] + 1;
                    count_q[c] = period_q[c];
                end
                else
                begin
                    count_q[c] = count_q[c] - dt;
                end
                if (!any_on || count_q[c] < least)
                    least = count_q[c];
                any_on = 1'b1;
            end
        end
        ev.kind    = mcpat_pkg::KIND_SUMMARY;
        ev.chan    = '0;
        ev.seq_no  = '0;
        ev.sleep   = any_on ? least : idle_q;
        ev.is_last = 1'b1;
        timer_events.insert(timer_events.size(), ev);
    endtask

    task automatic check_result();
        timer_event_t want;
        if (timer_events.size() == 0)
        begin
            if (fail_count < REPORT_LIMIT)
                $display("[%0t] unexpected result: kind=%0d ch=%0d seq=%0d sleep=%0d last=%0d",
                         $time, kind, channel, sequence_res, sleep_ticks, last);
            fail_count++;
        end
        else
        begin
            want = timer_events.pop_front();
            if (want.kind !== kind || want.chan !== channel || want.seq_no !== sequence_res ||
                want.sleep !== sleep_ticks || want.is_last !== last)
            begin
                if (fail_count < REPORT_LIMIT)
                begin
                    $display("[%0t] mismatch: expected kind=%0d ch=%0d seq=%0d sleep=%0d last=%0d",
                             $time, want.kind, want.chan, want.seq_no, want.sleep,
                             want.is_last);
                    $display("[%0t]           actual   kind=%0d ch=%0d seq=%0d sleep=%0d last=%0d",
                             $time, kind, channel, sequence_res, sleep_ticks, last);
                end
                fail_count++;
            end
        end
    endtask

    // Monitor: everything sampled at the rising edge. A result is checked
    // before the tick accepted on the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                advance_channels(elapsed);
            if (cfg_we)
                apply_reg_write(cfg_index, cfg_wdata);
        end
    end

    // Receiver back-pressure, redrawn every falling edge.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any transfer or register write restarts the count.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("multi_channel_periodic_alarm_timer_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one tick, with random idle cycles ahead of it, and return at
    // the edge where the transfer happens. valid stays high afterwards so a
    // back-to-back tick needs no low cycle; hold_input drops it otherwise.
    task automatic send_tick(input logic [mcpat_pkg::TIME_W-1:0] dt);
        int idle_run;
        idle_run = 0;
        @(negedge clk);
        while (idle_run < GAP_CAP && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            idle_run++;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        elapsed  <= dt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic hold_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Stop sending, let every owed result out, then let the block settle.
    task automatic wait_drained();
        hold_input();
        while (timer_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes go out on consecutive cycles; end_writes drops the enable.
    task automatic write_reg(input logic [mcpat_pkg::CFG_W-1:0] idx,
                             input logic [mcpat_pkg::TIME_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_timer(input logic [mcpat_pkg::TIME_W-1:0] p0,
                                 input logic [mcpat_pkg::TIME_W-1:0] p1,
                                 input logic [mcpat_pkg::TIME_W-1:0] p2,
                                 input logic [mcpat_pkg::TIME_W-1:0] p3,
                                 input logic [mcpat_pkg::TIME_W-1:0] idle_val);
        wait_drained();
        write_reg(REG_PERIOD_CH0, p0);
        write_reg(REG_PERIOD_CH1, p1);
        write_reg(REG_PERIOD_CH2, p2);
        write_reg(REG_PERIOD_CH3, p3);
        write_reg(mcpat_pkg::IDX_IDLE, idle_val);
        end_writes();
    endtask

    // Mostly short periods so alarms are frequent; extremes and unused mixed in.
    function automatic logic [mcpat_pkg::TIME_W-1:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        else if (r < 25)
            return mcpat_pkg::TIME_W'(1);
        else if (r < 32)
            return '1;
        else if (r < 78)
            return mcpat_pkg::TIME_W'($urandom_range(40, 2));
        else
            return mcpat_pkg::TIME_W'($urandom);
    endfunction

    function automatic logic [mcpat_pkg::TIME_W-1:0] pick_elapsed();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 17)
            return '1;
        else if (r < 70)
            return mcpat_pkg::TIME_W'($urandom_range(12, 0));
        else if (r < 86)
            return mcpat_pkg::TIME_W'($urandom_range(64, 0));
        else
            return mcpat_pkg::TIME_W'($urandom);
    endfunction

    // Rewrite a random subset of registers, so some channels keep counting
    // through the change and others restart.
    task automatic reshuffle_config();
        logic wrote;
        wrote = 1'b0;
        wait_drained();
        for (int c = 0; c < mcpat_pkg::CHANNELS; c++)
        begin
            if ($urandom_range(99) < 70)
            begin
                write_reg(mcpat_pkg::CFG_W'(REG_PERIOD_CH0 + c), pick_period());
                wrote = 1'b1;
            end
        end
        if ($urandom_range(99) < 50)
        begin
            write_reg(mcpat_pkg::IDX_IDLE,
                      ($urandom_range(3) == 0) ? '1 : mcpat_pkg::TIME_W'($urandom));
            wrote = 1'b1;
        end
        if ($urandom_range(99) < 15)
        begin
            write_reg(mcpat_pkg::CFG_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                      mcpat_pkg::TIME_W'($urandom));
            wrote = 1'b1;
        end
        if (wrote)
            end_writes();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset nothing is enabled: summary carries idle_sleep 1.
    task automatic test_reset_defaults();
        send_tick('0);
        send_tick('1);
    endtask

    // idle_sleep at both extremes; writes past the register map are ignored.
    task automatic test_idle_sleep();
        program_timer('0, '0, '0, '0, '0);
        send_tick(16'd5);
        program_timer('0, '0, '0, '0, '1);
        send_tick('0);
        wait_drained();
        for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
            write_reg(mcpat_pkg::CFG_W'(r), 16'h0003);
        end_writes();
        send_tick('1);
    endtask

    // One channel: zero elapsed, partial count, exact hit, overshoot with
    // no catch-up.
    task automatic test_single_channel();
        program_timer(16'd5, '0, '0, '0, 16'd1);
        send_tick('0);
        send_tick(16'd3);
        send_tick(16'd2);
        send_tick(16'd4);
        send_tick('1);
    endtask

    // Several channels, an unused one in the middle, all four firing on one
    // tick, and a channel switched off while others run.
    task automatic test_all_channels();
        program_timer(16'd1, 16'd2, '0, '1, 16'd9);
        send_tick(16'd1);
        send_tick(16'd1);
        send_tick('1);
        program_timer(16'd1, 16'd7, '1, '1, 16'd9);
        send_tick('1);
        send_tick('0);
        wait_drained();
        write_reg(REG_PERIOD_CH0, '0);
        end_writes();
        send_tick(16'd3);
    endtask

    // Sender waits for the previous tick's results every time.
    task automatic test_drain_pause();
        recv_stall_pct = 62;
        program_timer(16'd3, 16'd4, 16'd2, 16'd6, 16'd1);
        for (int k = 0; k < 4; k++)
        begin
            wait_drained();
            send_tick(16'd2);
        end
        recv_stall_pct = 0;
    endtask

    task automatic run_random_phase(input int n_ticks, input int send_pct,
                                    input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int k = 0; k < n_ticks; k++)
        begin
            if (k % 25 == 0)
                reshuffle_config();
            else if ($urandom_range(39) == 0)
                wait_drained();
            send_tick(pick_elapsed());
        end
    endtask

    // Random traffic over the four back-pressure profiles.
    task automatic test_random_traffic();
        run_random_phase(100, 0, 0);
        run_random_phase(100, 62, 0);
        run_random_phase(100, 0, 62);
        run_random_phase(100, 35, 35);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        clear_timer_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_idle_sleep();
        test_single_channel();
        test_all_channels();
        test_drain_pause();
        test_random_traffic();

        wait_drained();
        if (fail_count == 0 && timer_events.size() == 0)
            $display("multi_channel_periodic_alarm_timer_tb OK");
        else
            $display("multi_channel_periodic_alarm_timer_tb NOT OK");
        $finish;
    end

endmodule
